@@ design/mfas_pkg.sv @@
package mfas_pkg;

	// item actions
	localparam logic [1:0] ACTION_WEIGHT = 2'd0;
	localparam logic [1:0] ACTION_BIAS   = 2'd1;
	localparam logic [1:0] ACTION_SAMPLE = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd2;

	// result status codes
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_MISMATCH = 1'b1;

	// accumulator holds 24 fractional bits, quotient is the accumulator over 2^16
	localparam int ACC_W = 52;
	localparam int QUO_W = ACC_W - 16;

	typedef struct packed {
		logic [1:0]         action;
		logic [2:0]         layer_index;
		logic [3:0]         source_index;
		logic [3:0]         dest_index;
		logic signed [15:0] value;
		logic               sample_last;
	} item_t;

	typedef struct packed {
		logic [15:0] activation;
		logic        status;
	} result_t;

	typedef enum logic [1:0] {
		TERM_BIAS,
		TERM_INPUT,
		TERM_HIDDEN
	} term_kind_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       sample_wr;
		logic [5:0] sample_addr;
		logic       issue;
		term_kind_t kind;
		logic [3:0] layer;
		logic [5:0] src;
		logic [3:0] dest;
		logic       cur;
		logic [5:0] fan;
		logic       div_start;
		logic       sig_load;
		logic       act_write;
		logic       out_load;
		logic       out_err;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic out_free;
	} dp_status_t;

	// sigmoid sample points at x = 0, 0.5, ..., 8
	function automatic logic [15:0] sig_point(input logic [4:0] idx);
		logic [15:0] v;
		case (idx)
			5'd0:    v = 16'd32768;
			5'd1:    v = 16'd40793;
			5'd2:    v = 16'd47911;
			5'd3:    v = 16'd53581;
			5'd4:    v = 16'd57724;
			5'd5:    v = 16'd60565;
			5'd6:    v = 16'd62428;
			5'd7:    v = 16'd63615;
			5'd8:    v = 16'd64357;
			5'd9:    v = 16'd64816;
			5'd10:   v = 16'd65097;
			5'd11:   v = 16'd65269;
			5'd12:   v = 16'd65374;
			5'd13:   v = 16'd65438;
			5'd14:   v = 16'd65476;
			5'd15:   v = 16'd65500;
			default: v = 16'd65514;
		endcase
		return v;
	endfunction

	// table sigmoid with linear interpolation, Q8.8 in, Q0.16 out
	function automatic logic [15:0] sigmoid_q16(input logic signed [15:0] x);
		logic [15:0] a;
		logic [8:0]  i;
		logic [6:0]  f;
		logic [15:0] t0;
		logic [15:0] t1;
		logic [19:0] slope;
		logic [16:0] v;
		a = x[15] ? 16'(-x) : 16'(x);
		i = a[15:7];
		f = a[6:0];
		if (i >= 9'd16) begin
			v = 17'(sig_point(5'd16));
		end else begin
			t0 = sig_point(i[4:0]);
			t1 = sig_point(5'(i[4:0] + 5'd1));
			slope = 20'(t1 - t0) * 20'(f) + 20'd64;
			v = 17'(t0) + 17'(slope[19:7]);
		end
		if (x[15]) begin
			v = 17'h10000 - v;
		end
		return v[15:0];
	endfunction

endpackage

@@ design/mfas_ram.sv @@
module mfas_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/mfas_ctrl.sv @@
module mfas_ctrl #(
	parameter int MAX_INPUTS = 16,
	parameter int MAX_NODES  = 10,
	parameter int MAX_LAYERS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [mfas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfas_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic [1:0]                      item_action,
	input  logic                            item_last,
	input  mfas_pkg::dp_status_t            status,
	output mfas_pkg::ctrl_cmd_t             cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NODE,
		ST_TERM,
		ST_DRAIN,
		ST_DIV_START,
		ST_DIV,
		ST_SIG,
		ST_NEXT,
		ST_OUT,
		ST_ERR
	} state_t;

	state_t      state_q;
	logic [4:0]  in_cnt_q;
	logic [3:0]  lay_cnt_q;
	logic [3:0]  node_cnt_q;
	logic [4:0]  smp_cnt_q;
	logic [3:0]  l_q;
	logic [3:0]  j_q;
	logic [5:0]  p_q;
	logic [5:0]  fan_q;
	logic        cur_q;
	logic        drain_q;

	logic        accept;
	logic        is_sample;
	logic [4:0]  smp_next;
	logic        mismatch;
	logic [4:0]  layers_c;
	logic [3:0]  nodes_c;
	logic        last_layer;

	// clamped layer and node counts
	always_comb begin
		if (lay_cnt_q == 4'd0) begin
			layers_c = 5'd1;
		end else if (int'(lay_cnt_q) > MAX_LAYERS) begin
			layers_c = 5'(MAX_LAYERS);
		end else begin
			layers_c = 5'(lay_cnt_q);
		end
		if (node_cnt_q == 4'd0) begin
			nodes_c = 4'd1;
		end else if (int'(node_cnt_q) > MAX_NODES) begin
			nodes_c = 4'(MAX_NODES);
		end else begin
			nodes_c = node_cnt_q;
		end
	end

	assign last_layer = (5'(l_q) == layers_c - 5'd1);
	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign is_sample  = (item_action == mfas_pkg::ACTION_SAMPLE);
	assign smp_next   = (smp_cnt_q < 5'd31) ? smp_cnt_q + 5'd1 : smp_cnt_q;
	assign mismatch   = (in_cnt_q == 5'd0) || (int'(in_cnt_q) > MAX_INPUTS)
		|| (smp_next != in_cnt_q);

	// commands to the datapath
	always_comb begin
		cmd             = '0;
		cmd.load        = accept;
		cmd.sample_wr   = int'(smp_cnt_q) < MAX_INPUTS;
		cmd.sample_addr = 6'(smp_cnt_q);
		cmd.kind        = mfas_pkg::TERM_BIAS;
		cmd.layer       = l_q;
		cmd.src         = p_q;
		cmd.dest        = j_q;
		cmd.cur         = cur_q;
		cmd.fan         = fan_q;
		case (state_q)
			ST_NODE: begin
				cmd.issue = 1'b1;
			end
			ST_TERM: begin
				cmd.issue = 1'b1;
				cmd.kind  = (l_q == 4'd0) ? mfas_pkg::TERM_INPUT : mfas_pkg::TERM_HIDDEN;
			end
			ST_DIV_START: cmd.div_start = 1'b1;
			ST_SIG:       cmd.sig_load  = 1'b1;
			ST_NEXT:      cmd.act_write = !last_layer;
			ST_OUT:       cmd.out_load  = status.out_free;
			ST_ERR:       cmd.out_err   = status.out_free;
			default: ;
		endcase
	end

	// state, configuration and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_cnt_q   <= 5'd16;
			lay_cnt_q  <= 4'd4;
			node_cnt_q <= 4'd10;
			smp_cnt_q  <= 5'd0;
			l_q        <= 4'd0;
			j_q        <= 4'd0;
			p_q        <= 6'd0;
			fan_q      <= 6'd0;
			cur_q      <= 1'b0;
			drain_q    <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					mfas_pkg::REG_INPUT_COUNT: in_cnt_q   <= cfg_data;
					mfas_pkg::REG_LAYER_COUNT: lay_cnt_q  <= cfg_data[3:0];
					mfas_pkg::REG_NODE_COUNT:  node_cnt_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && is_sample) begin
						smp_cnt_q <= smp_next;
						if (item_last) begin
							smp_cnt_q <= 5'd0;
							if (mismatch) begin
								state_q <= ST_ERR;
							end else begin
								l_q     <= 4'd0;
								j_q     <= 4'd0;
								cur_q   <= 1'b0;
								fan_q   <= 6'(in_cnt_q);
								state_q <= ST_NODE;
							end
						end
					end
				end
				ST_NODE: begin
					p_q     <= 6'd0;
					state_q <= ST_TERM;
				end
				ST_TERM: begin
					if (p_q == fan_q - 6'd1) begin
						drain_q <= 1'b0;
						state_q <= ST_DRAIN;
					end else begin
						p_q <= p_q + 6'd1;
					end
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= ST_DIV_START;
					end
				end
				ST_DIV_START: state_q <= ST_DIV;
				ST_DIV: begin
					if (status.div_done) begin
						state_q <= ST_SIG;
					end
				end
				ST_SIG: state_q <= ST_NEXT;
				ST_NEXT: begin
					if (last_layer) begin
						state_q <= ST_OUT;
					end else if (j_q == nodes_c - 4'd1) begin
						j_q     <= 4'd0;
						l_q     <= l_q + 4'd1;
						cur_q   <= !cur_q;
						fan_q   <= 6'(nodes_c);
						state_q <= ST_NODE;
					end else begin
						j_q     <= j_q + 4'd1;
						state_q <= ST_NODE;
					end
				end
				ST_OUT, ST_ERR: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// frame counter is cleared for the whole inference
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (smp_cnt_q == 5'd0))
		else $error("sample counter not cleared during inference");

	// divider must be free when a node is handed to it
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_START) |-> !status.div_busy)
		else $error("divider started while busy");

	// term index stays inside the fan-in
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TERM) |-> (p_q < fan_q))
		else $error("term index beyond fan-in");

endmodule

@@ design/mfas_dp.sv @@
module mfas_dp #(
	parameter int MAX_INPUTS = 16,
	parameter int MAX_NODES  = 10,
	parameter int MAX_LAYERS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mfas_pkg::item_t      item,
	input  mfas_pkg::ctrl_cmd_t  cmd,
	output mfas_pkg::dp_status_t status,
	output logic                 result_valid,
	input  logic                 result_ready,
	output mfas_pkg::result_t    result
);

	localparam int SRC_SLOTS = (MAX_INPUTS > MAX_NODES) ? MAX_INPUTS : MAX_NODES;
	localparam int WT_DEPTH  = MAX_LAYERS * SRC_SLOTS * MAX_NODES;
	localparam int BS_DEPTH  = MAX_LAYERS * MAX_NODES;
	localparam int ACT_DEPTH = 2 * MAX_NODES;
	localparam int WT_AW     = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
	localparam int BS_AW     = (BS_DEPTH > 1) ? $clog2(BS_DEPTH) : 1;
	localparam int SMP_AW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int ACT_AW    = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
	localparam int ACC_W     = mfas_pkg::ACC_W;
	localparam int QUO_W     = mfas_pkg::QUO_W;

	// store write decode
	logic              wt_we;
	logic              bs_we;
	logic              smp_we;
	logic [WT_AW-1:0]  wt_waddr;
	logic [BS_AW-1:0]  bs_waddr;
	logic [WT_AW-1:0]  wt_raddr;
	logic [BS_AW-1:0]  bs_raddr;
	logic [ACT_AW-1:0] act_waddr;
	logic [ACT_AW-1:0] act_raddr;
	logic [15:0]       wt_rd;
	logic [15:0]       bs_rd;
	logic [15:0]       smp_rd;
	logic [15:0]       act_rd;

	assign wt_we = cmd.load && (item.action == mfas_pkg::ACTION_WEIGHT)
		&& (int'(item.layer_index) < MAX_LAYERS) && (int'(item.source_index) < SRC_SLOTS)
		&& (int'(item.dest_index) < MAX_NODES);
	assign bs_we = cmd.load && (item.action == mfas_pkg::ACTION_BIAS)
		&& (int'(item.layer_index) < MAX_LAYERS) && (int'(item.dest_index) < MAX_NODES);
	assign smp_we = cmd.load && (item.action == mfas_pkg::ACTION_SAMPLE) && cmd.sample_wr;

	assign wt_waddr = WT_AW'((int'(item.layer_index) * SRC_SLOTS + int'(item.source_index))
		* MAX_NODES + int'(item.dest_index));
	assign bs_waddr = BS_AW'(int'(item.layer_index) * MAX_NODES + int'(item.dest_index));
	assign wt_raddr = WT_AW'((int'(cmd.layer) * SRC_SLOTS + int'(cmd.src)) * MAX_NODES
		+ int'(cmd.dest));
	assign bs_raddr = BS_AW'(int'(cmd.layer) * MAX_NODES + int'(cmd.dest));
	assign act_waddr = ACT_AW'(int'(cmd.cur) * MAX_NODES + int'(cmd.dest));
	assign act_raddr = ACT_AW'(int'(!cmd.cur) * MAX_NODES + int'(cmd.src));

	mfas_ram #(.WIDTH(16), .DEPTH(WT_DEPTH)) u_weight_ram (
		.clk   (clk),
		.we    (wt_we),
		.waddr (wt_waddr),
		.wdata (item.value),
		.raddr (wt_raddr),
		.rdata (wt_rd)
	);

	mfas_ram #(.WIDTH(16), .DEPTH(BS_DEPTH)) u_bias_ram (
		.clk   (clk),
		.we    (bs_we),
		.waddr (bs_waddr),
		.wdata (item.value),
		.raddr (bs_raddr),
		.rdata (bs_rd)
	);

	mfas_ram #(.WIDTH(16), .DEPTH(MAX_INPUTS)) u_sample_ram (
		.clk   (clk),
		.we    (smp_we),
		.waddr (SMP_AW'(cmd.sample_addr)),
		.wdata (item.value),
		.raddr (SMP_AW'(cmd.src)),
		.rdata (smp_rd)
	);

	logic [15:0] sig_q;

	mfas_ram #(.WIDTH(16), .DEPTH(ACT_DEPTH)) u_act_ram (
		.clk   (clk),
		.we    (cmd.act_write),
		.waddr (act_waddr),
		.wdata (sig_q),
		.raddr (act_raddr),
		.rdata (act_rd)
	);

	// multiply-accumulate pipeline: read, multiply, accumulate
	logic                    issue_s1;
	mfas_pkg::term_kind_t    kind_s1;
	logic                    valid_s2;
	logic                    bias_s2;
	logic signed [ACC_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [16:0]      op_a;
	logic signed [32:0]      mult;
	logic signed [ACC_W-1:0] term_val;

	assign op_a = (kind_s1 == mfas_pkg::TERM_INPUT) ? {smp_rd[15], smp_rd} : {1'b0, act_rd};
	assign mult = op_a * $signed(wt_rd);

	always_comb begin
		case (kind_s1)
			mfas_pkg::TERM_BIAS:
				term_val = {{(ACC_W-32){bs_rd[15]}}, bs_rd, 16'd0};
			mfas_pkg::TERM_INPUT:
				term_val = {{(ACC_W-49){mult[32]}}, mult, 16'd0};
			default:
				term_val = {{(ACC_W-33){mult[32]}}, mult};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			issue_s1 <= cmd.issue;
			valid_s2 <= issue_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= cmd.kind;
		prod_s2 <= term_val;
		bias_s2 <= (kind_s1 == mfas_pkg::TERM_BIAS);
		if (valid_s2) begin
			acc_q <= bias_s2 ? prod_s2 : acc_q + prod_s2;
		end
	end

	// shared restoring divider, one quotient bit a cycle, rounding to nearest with ties upward
	logic [QUO_W-1:0]        div_num_q;
	logic [QUO_W-1:0]        div_quo_q;
	logic [6:0]              div_rem_q;
	logic [5:0]              div_den_q;
	logic [5:0]              div_cnt_q;
	logic                    div_neg_q;
	logic                    div_busy_q;
	logic                    div_fin_q;
	logic                    div_done_q;
	logic signed [15:0]      pre_q;
	logic [5:0]              den_c;
	logic signed [ACC_W-1:0] numer;
	logic [QUO_W-1:0]        x_c;
	logic [6:0]              rem_sh;
	logic                    rem_ge;
	logic [QUO_W:0]          qmag;
	logic signed [15:0]      pre_c;

	assign den_c  = cmd.fan + 6'd1;
	assign numer  = acc_q + (ACC_W'(den_c) << 15);
	assign x_c    = numer[ACC_W-1:16];
	assign rem_sh = {div_rem_q[5:0], div_num_q[QUO_W-1]};
	assign rem_ge = rem_sh >= {1'b0, div_den_q};
	assign qmag   = (QUO_W+1)'(div_quo_q)
		+ (QUO_W+1)'(div_neg_q && (div_rem_q != 7'd0));

	always_comb begin
		if (div_neg_q) begin
			pre_c = (qmag > (QUO_W+1)'(32768)) ? 16'sh8000 : 16'(-qmag);
		end else begin
			pre_c = (qmag > (QUO_W+1)'(32767)) ? 16'sh7fff : 16'(qmag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_fin_q  <= 1'b0;
			div_done_q <= 1'b0;
			div_cnt_q  <= 6'd0;
		end else begin
			div_fin_q <= 1'b0;
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				div_done_q <= 1'b0;
				div_cnt_q  <= 6'd0;
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q + 6'd1;
				if (div_cnt_q == 6'(QUO_W - 1)) begin
					div_busy_q <= 1'b0;
					div_fin_q  <= 1'b1;
				end
			end else if (div_fin_q) begin
				div_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_num_q <= x_c[QUO_W-1] ? QUO_W'(-x_c) : x_c;
			div_neg_q <= x_c[QUO_W-1];
			div_den_q <= den_c;
			div_rem_q <= 7'd0;
			div_quo_q <= '0;
		end else if (div_busy_q) begin
			div_num_q <= {div_num_q[QUO_W-2:0], 1'b0};
			div_rem_q <= rem_ge ? rem_sh - {1'b0, div_den_q} : rem_sh;
			div_quo_q <= {div_quo_q[QUO_W-2:0], rem_ge};
		end
		if (div_fin_q) begin
			pre_q <= pre_c;
		end
		if (cmd.sig_load) begin
			sig_q <= mfas_pkg::sigmoid_q16(pre_q);
		end
	end

	// result register, frees when the consumer takes the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (cmd.out_load || cmd.out_err) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result.activation <= sig_q;
			result.status     <= mfas_pkg::STATUS_OK;
		end else if (cmd.out_err) begin
			result.activation <= 16'd0;
			result.status     <= mfas_pkg::STATUS_MISMATCH;
		end
	end

	assign status.div_busy = div_busy_q || div_fin_q;
	assign status.div_done = div_done_q;
	assign status.out_free = !result_valid || result_ready;

	// a fresh division never reports done on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !div_done_q)
		else $error("divider done flag not cleared on start");

endmodule

@@ design/mlp_forward_average_sigmoid_core.sv @@
// channel   | handshake                   | payload
// item      | item_valid / item_ready     | item (action, indexes, value, sample_last)
// result    | result_valid / result_ready | result (activation, status)
// config    | cfg_write_en                | cfg_index, cfg_data
//
// weight, bias and plain sample transfers are taken back to back while idle.
// a last sample runs the network node by node, through the single
// multiply-accumulate lane and the shared 36-step divider.
// reset clears control and loads the configuration defaults; the weight,
// bias, sample and activation memories hold nothing defined until written.
// a waiting result sits in its own register; loads are still taken meanwhile.
module mlp_forward_average_sigmoid_core #(
	parameter int MAX_INPUTS = 16,
	parameter int MAX_NODES  = 10,
	parameter int MAX_LAYERS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [mfas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfas_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  mfas_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output mfas_pkg::result_t               result
);

	mfas_pkg::ctrl_cmd_t  cmd;
	mfas_pkg::dp_status_t status;

	mfas_ctrl #(
		.MAX_INPUTS (MAX_INPUTS),
		.MAX_NODES  (MAX_NODES),
		.MAX_LAYERS (MAX_LAYERS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_action  (item.action),
		.item_last    (item.sample_last),
		.status       (status),
		.cmd          (cmd)
	);

	mfas_dp #(
		.MAX_INPUTS (MAX_INPUTS),
		.MAX_NODES  (MAX_NODES),
		.MAX_LAYERS (MAX_LAYERS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	// codes the block has to ignore
	localparam logic [1:0] ACTION_UNUSED = 2'd3;
	localparam logic [mfas_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int N_LAYERS = 8;
	localparam int N_SRC    = 16;
	localparam int N_NODES  = 10;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_write_en = 1'b0;
	logic [mfas_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [mfas_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            item_valid = 1'b0;
	logic                            item_ready;
	mfas_pkg::item_t                 item = '0;
	logic                            result_valid;
	logic                            result_ready = 1'b0;
	mfas_pkg::result_t               result;

	mlp_forward_average_sigmoid_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// pending items, expected results, idling knobs
	mfas_pkg::item_t   pending_items[$];
	mfas_pkg::result_t expected_results[$];
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      hold_left = 0;
	int      mismatches = 0;
	bit      item_taken = 1'b0;
	int      gen_total = 0;

	// shadow network state
	int          cnt_inputs = 16;
	int          cnt_layers = 4;
	int          cnt_nodes = 10;
	shortint     w_mem[N_LAYERS][N_SRC][N_NODES];
	shortint     b_mem[N_LAYERS][N_NODES];
	shortint     frame_samples[N_SRC];
	int          frame_fill = 0;
	int          hidden[2][N_NODES];
	int          sig_pts[17] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615,
		64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};

	// generator side: which store entries have been loaded
	bit w_loaded[N_LAYERS][N_SRC][N_NODES];
	bit b_loaded[N_LAYERS][N_NODES];

	function automatic int node_average(longint acc, longint cnt);
		longint d;
		longint n;
		longint q;
		d = cnt * 65536;
		n = acc + d / 2;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q--;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return int'(q);
	endfunction

	function automatic int squash(int x);
		int a;
		int i;
		int f;
		int v;
		a = x < 0 ? -x : x;
		i = a >> 7;
		f = a & 127;
		if (i >= 16)
			v = sig_pts[16];
		else
			v = sig_pts[i] + (((sig_pts[i+1] - sig_pts[i]) * f + 64) >> 7);
		if (x < 0)
			v = 65536 - v;
		if (v > 65535) v = 65535;
		return v;
	endfunction

	function automatic int clamp(int v, int hi);
		return v < 1 ? 1 : (v > hi ? hi : v);
	endfunction

	// forward pass over the shadow stores
	function automatic int forward_pass();
		int layers;
		int nodes;
		int fan;
		int cur;
		int dests;
		longint acc;
		int pre;
		layers = clamp(cnt_layers, N_LAYERS);
		nodes = clamp(cnt_nodes, N_NODES);
		fan = cnt_inputs;
		cur = 0;
		for (int l = 0; l < layers; l++) begin
			dests = (l == layers - 1) ? 1 : nodes;
			for (int j = 0; j < dests; j++) begin
				acc = longint'(b_mem[l][j]) * 65536;
				for (int p = 0; p < fan; p++) begin
					if (l == 0)
						acc += longint'(frame_samples[p]) * longint'(w_mem[l][p][j]) * 65536;
					else
						acc += longint'(hidden[cur ^ 1][p]) * longint'(w_mem[l][p][j]);
				end
				pre = node_average(acc, fan + 1);
				if (l == layers - 1)
					return squash(pre);
				hidden[cur][j] = squash(pre);
			end
			cur ^= 1;
			fan = nodes;
		end
		return 0;
	endfunction

	// update shadow state for one accepted transfer
	task automatic absorb_item(mfas_pkg::item_t it);
		mfas_pkg::result_t r;
		if (it.action == mfas_pkg::ACTION_WEIGHT) begin
			if (it.dest_index < N_NODES)
				w_mem[it.layer_index][it.source_index][it.dest_index] = it.value;
		end else if (it.action == mfas_pkg::ACTION_BIAS) begin
			if (it.dest_index < N_NODES)
				b_mem[it.layer_index][it.dest_index] = it.value;
		end else if (it.action == mfas_pkg::ACTION_SAMPLE) begin
			if (frame_fill < N_SRC)
				frame_samples[frame_fill] = it.value;
			if (frame_fill < 31)
				frame_fill++;
			if (it.sample_last) begin
				if (cnt_inputs == 0 || cnt_inputs > N_SRC || frame_fill != cnt_inputs) begin
					r.activation = '0;
					r.status = mfas_pkg::STATUS_MISMATCH;
				end else begin
					r.activation = 16'(forward_pass());
					r.status = mfas_pkg::STATUS_OK;
				end
				expected_results = {expected_results, r};
				frame_fill = 0;
			end
		end
	endtask

	task automatic report(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// input driver
	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_taken)) begin
			item_taken = 1'b0;
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				item <= pending_items.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver stalls
	always @(negedge clk)
		result_ready <= arst_n && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;

	// long hold-off countdown
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left--;
	end

	// monitor both channels
	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready) begin
			item_taken = 1'b1;
			absorb_item(item);
		end
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				report("unexpected result transfer", result.activation, -1);
			end else begin
				if (result.activation != expected_results[0].activation)
					report("activation", result.activation, expected_results[0].activation);
				if (result.status != expected_results[0].status)
					report("status", result.status, expected_results[0].status);
				void'(expected_results.pop_front());
			end
		end
	end

	function automatic logic signed [15:0] rand_value(int wide);
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return wide ? 16'($urandom) : 16'($signed($urandom_range(1023)) - 512);
		endcase
	endfunction

	task automatic push_load(logic [1:0] act, int l, int s, int d, logic signed [15:0] v);
		mfas_pkg::item_t it;
		it.action = act;
		it.layer_index = 3'(l);
		it.source_index = 4'(s);
		it.dest_index = 4'(d);
		it.value = v;
		it.sample_last = 1'($urandom_range(1));
		if (d < N_NODES) begin
			if (act == mfas_pkg::ACTION_WEIGHT) w_loaded[l][s][d] = 1'b1;
			if (act == mfas_pkg::ACTION_BIAS) b_loaded[l][d] = 1'b1;
		end
		pending_items = {pending_items, it};
		gen_total++;
	endtask

	// loads that a full pass will read but nobody has written yet
	task automatic fill_missing(int ic, int lc, int nc);
		int layers;
		int nodes;
		int fan;
		int dests;
		layers = clamp(lc, N_LAYERS);
		nodes = clamp(nc, N_NODES);
		fan = ic;
		for (int l = 0; l < layers; l++) begin
			dests = (l == layers - 1) ? 1 : nodes;
			for (int j = 0; j < dests; j++) begin
				if (!b_loaded[l][j])
					push_load(mfas_pkg::ACTION_BIAS, l, $urandom_range(15), j,
						rand_value($urandom_range(1)));
				for (int p = 0; p < fan; p++)
					if (!w_loaded[l][p][j])
						push_load(mfas_pkg::ACTION_WEIGHT, l, p, j,
							rand_value($urandom_range(1)));
			end
			fan = nodes;
		end
	endtask

	task automatic push_frame(int n, int wide);
		mfas_pkg::item_t it;
		for (int k = 0; k < n; k++) begin
			it = '0;
			it.action = mfas_pkg::ACTION_SAMPLE;
			it.layer_index = 3'($urandom);
			it.source_index = 4'($urandom);
			it.dest_index = 4'($urandom);
			it.value = wide ? 16'($urandom) : 16'($signed($urandom_range(255)) - 128);
			it.sample_last = (k == n - 1);
			pending_items = {pending_items, it};
			gen_total++;
		end
	endtask

	// items the block has to ignore
	task automatic push_noise();
		mfas_pkg::item_t it;
		it = mfas_pkg::item_t'(30'($urandom));
		case ($urandom_range(2))
			0: it.action = ACTION_UNUSED;
			1: begin
				it.action = mfas_pkg::ACTION_WEIGHT;
				it.dest_index = 4'($urandom_range(15, N_NODES));
			end
			default: begin
				it.action = mfas_pkg::ACTION_BIAS;
				it.dest_index = 4'($urandom_range(15, N_NODES));
			end
		endcase
		pending_items = {pending_items, it};
		gen_total++;
	endtask

	task automatic push_random_frame();
		int shape;
		int n;
		int ic_ok;
		ic_ok = cnt_inputs >= 1 && cnt_inputs <= N_SRC;
		shape = $urandom_range(99);
		if (shape < 75 && ic_ok) begin
			fill_missing(cnt_inputs, cnt_layers, cnt_nodes);
			for (int k = $urandom_range(3); k > 0; k--)
				push_load($urandom_range(1) ? mfas_pkg::ACTION_WEIGHT : mfas_pkg::ACTION_BIAS,
					$urandom_range(N_LAYERS - 1), $urandom_range(N_SRC - 1),
					$urandom_range(N_NODES - 1), rand_value(1));
			push_frame(cnt_inputs, $urandom_range(1));
		end else if (shape < 92) begin
			do n = $urandom_range(20, 1); while (n == cnt_inputs);
			push_frame(n, 1);
		end else begin
			push_frame($urandom_range(34, 17), 1);
		end
		if ($urandom_range(9) == 0)
			push_noise();
	endtask

	task automatic write_reg(logic [mfas_pkg::CFG_IDX_W-1:0] idx, int v);
		@(negedge clk);
		cfg_write_en = 1'b1;
		cfg_index = idx;
		cfg_data = mfas_pkg::CFG_DATA_W'(v);
		@(negedge clk);
		cfg_write_en = 1'b0;
		if (idx == mfas_pkg::REG_INPUT_COUNT) cnt_inputs = v & 31;
		else if (idx == mfas_pkg::REG_LAYER_COUNT) cnt_layers = v & 15;
		else if (idx == mfas_pkg::REG_NODE_COUNT) cnt_nodes = v & 15;
	endtask

	task automatic set_network(int ic, int lc, int nc);
		write_reg(mfas_pkg::REG_INPUT_COUNT, ic);
		write_reg(mfas_pkg::REG_LAYER_COUNT, lc);
		write_reg(mfas_pkg::REG_NODE_COUNT, nc);
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_idling(int phase);
		case (phase % 4)
			0: begin send_idle_pct = 0; recv_stall_pct = 0; end
			1: begin send_idle_pct = 48; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 48; end
			default: begin send_idle_pct = 11; recv_stall_pct = 11; end
		endcase
	endtask

	task automatic run_frames(int frames);
		for (int k = 0; k < frames; k++)
			push_random_frame();
		drain();
	endtask

	initial begin
		mfas_pkg::item_t it;
		int phase;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset configuration, directed corners
		it = '0;
		it.action = ACTION_UNUSED;
		it.value = 16'sh7FFF;
		pending_items = {pending_items, it};
		push_load(mfas_pkg::ACTION_WEIGHT, 7, 15, 12, 16'sh8000);
		push_load(mfas_pkg::ACTION_BIAS, 7, 15, 15, 16'sh7FFF);
		fill_missing(16, 4, 10);
		push_frame(16, 1);
		push_frame(3, 1);
		push_frame(20, 1);
		push_frame(16, 0);
		drain();

		// fixed settings including extremes and clamped values
		set_idling(1);
		set_network(1, 1, 1);
		run_frames(12);
		set_idling(2);
		set_network(16, 8, 10);
		run_frames(3);
		set_idling(3);
		set_network(0, 2, 3);
		run_frames(6);
		write_reg(REG_UNUSED, 31);
		set_network(31, 0, 0);
		run_frames(6);
		set_network(4, 0, 0);
		run_frames(8);
		set_idling(0);
		set_network(3, 15, 15);
		run_frames(2);
		set_network(17, 1, 1);
		run_frames(4);

		// receiver holds off while items keep coming
		set_network(2, 2, 2);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 600;
		run_frames(15);

		// random settings, mostly small networks
		phase = 0;
		while (gen_total < 1650) begin
			set_idling(phase);
			set_network($urandom_range(8, 1), $urandom_range(3, 1), $urandom_range(4, 1));
			run_frames($urandom_range(20, 8));
			phase++;
		end

		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
